/* design/rcpw_pkg.sv */
// ----------------------------------------------------------------------------
// RC pulse width capture package
// Shared types, channel codes and constants of the pulse width capture block.
// ----------------------------------------------------------------------------
package rcpw_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int NUM_CH         = 5;
  localparam int CH_BITS        = 3;
  localparam int WIDTH_BITS     = 15;
  localparam int FLAG_BITS      = 4;
  localparam int TIME_BITS      = 16;

  localparam logic MODE_EDGE    = 1'b0;
  localparam logic MODE_COLLECT = 1'b1;

  localparam logic LEVEL_LOW    = 1'b0;
  localparam logic LEVEL_HIGH   = 1'b1;

  localparam logic [CH_BITS-1:0] CH_THROTTLE = 3'd0;
  localparam logic [CH_BITS-1:0] CH_PITCH    = 3'd1;
  localparam logic [CH_BITS-1:0] CH_ROLL     = 3'd2;
  localparam logic [CH_BITS-1:0] CH_YAW      = 3'd3;
  localparam logic [CH_BITS-1:0] CH_HOVER    = 3'd4;

  localparam logic [FLAG_BITS-1:0] FLAG_THROTTLE = 4'd1;
  localparam logic [FLAG_BITS-1:0] FLAG_PITCH    = 4'd2;
  localparam logic [FLAG_BITS-1:0] FLAG_ROLL     = 4'd4;
  localparam logic [FLAG_BITS-1:0] FLAG_YAW      = 4'd8;
  localparam logic [FLAG_BITS-1:0] FLAG_NONE     = 4'd0;

  typedef logic [WIDTH_BITS-1:0] width_t;

  typedef struct packed {
    logic                 mode;
    logic [CH_BITS-1:0]   channel;
    logic                 level;
    logic [TIME_BITS-1:0] timer_now;
  } rcpw_in_t;

  typedef struct packed {
    logic [FLAG_BITS-1:0] update_flags;
    width_t               throttle_width;
    width_t               hover_width;
    width_t               pitch_width;
    width_t               roll_width;
    width_t               yaw_width;
  } rcpw_out_t;

  function automatic logic [FLAG_BITS-1:0] chan_flag(input logic [CH_BITS-1:0] ch);
    logic [FLAG_BITS-1:0] flag;
    unique case (ch) inside
      CH_THROTTLE, CH_HOVER: flag = FLAG_THROTTLE;
      CH_PITCH:              flag = FLAG_PITCH;
      CH_ROLL:               flag = FLAG_ROLL;
      CH_YAW:                flag = FLAG_YAW;
      default:               flag = FLAG_NONE;
    endcase
    return flag;
  endfunction

endpackage

/* design/rc_pulse_width_capture.sv */
// ----------------------------------------------------------------------------
// RC pulse width capture
// Measures high pulse widths on five receiver channels and reports them.
// ----------------------------------------------------------------------------
// An edge transfer on the in_ channel names a channel, its new pin level and
// the timer count at the edge. A rising edge stores the start time, a falling
// edge stores half the elapsed ticks as the channel's width and marks the
// channel updated; hover shares the throttle flag. A collect transfer yields
// one result on the out_ channel carrying the flags and all five widths, but
// only when a flag is set, and then clears the flags.
// Each transfer lands in an input register and is processed from there; a
// result is registered in the result register. One transfer is taken every
// cycle while in_ready is high; the input register and the result register
// together let the block keep accepting while a result waits. When the
// receiver stalls with a result held, a following collect that would produce
// a result waits in the input register and in_ready drops; edges and empty
// collects still pass. Reset clears all start times, widths and flags and
// empties both registers.
// ----------------------------------------------------------------------------
module rc_pulse_width_capture #(
  parameter int TIMER_BITS = rcpw_pkg::TIMER_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rcpw_pkg::rcpw_in_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rcpw_pkg::rcpw_out_t out_data
);
  import rcpw_pkg::*;

  logic                 stg_valid_r;
  rcpw_in_t             stg_item_r;
  logic                 out_valid_r;
  rcpw_out_t            out_data_r;
  logic [TIMER_BITS-1:0] edge_start_r [NUM_CH];
  width_t               pulse_width_r [NUM_CH];
  logic [FLAG_BITS-1:0] pending_flags_r;

  logic [TIMER_BITS-1:0] edge_start_nxt [NUM_CH];
  width_t               pulse_width_nxt [NUM_CH];
  logic [FLAG_BITS-1:0] pending_flags_nxt;
  logic                 out_valid_nxt;

  logic                 stg_collect;
  logic                 stg_result;
  logic                 stg_adv;
  logic                 ch_ok;
  logic [CH_BITS-1:0]   ch_idx;
  logic [31:0]          now_ext;
  logic [TIMER_BITS-1:0] now;
  logic [TIMER_BITS-1:0] start;
  logic [TIMER_BITS-1:0] diff;
  logic [31:0]          half_ext;
  width_t               new_width;

  assign stg_collect = stg_item_r.mode == MODE_COLLECT;
  assign stg_result  = stg_collect && (pending_flags_r != FLAG_NONE);
  assign stg_adv     = stg_valid_r && (!stg_result || !out_valid_r || out_ready);
  assign in_ready    = !stg_valid_r || stg_adv;

  assign ch_idx    = stg_item_r.channel;
  assign ch_ok     = 32'(ch_idx) < NUM_CH;
  assign now_ext   = 32'(stg_item_r.timer_now);
  assign now       = now_ext[TIMER_BITS-1:0];
  assign start     = ch_ok ? edge_start_r[ch_idx] : '0;
  assign diff      = now - start;
  assign half_ext  = 32'(diff[TIMER_BITS-1:1]);
  assign new_width = half_ext[WIDTH_BITS-1:0];

  always_comb begin
    edge_start_nxt    = edge_start_r;
    pulse_width_nxt   = pulse_width_r;
    pending_flags_nxt = pending_flags_r;
    if (stg_adv) begin
      if (stg_collect) begin
        pending_flags_nxt = FLAG_NONE;
      end else if (ch_ok) begin
        if (stg_item_r.level == LEVEL_HIGH) begin
          edge_start_nxt[ch_idx] = now;
        end else begin
          pulse_width_nxt[ch_idx] = new_width;
          pending_flags_nxt       = pending_flags_r | chan_flag(ch_idx);
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (stg_adv && stg_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r     <= 1'b0;
      out_valid_r     <= 1'b0;
      pending_flags_r <= FLAG_NONE;
      for (int i = 0; i < NUM_CH; i++) begin
        edge_start_r[i]  <= '0;
        pulse_width_r[i] <= '0;
      end
    end else begin
      stg_valid_r     <= in_valid || (stg_valid_r && !stg_adv);
      out_valid_r     <= out_valid_nxt;
      pending_flags_r <= pending_flags_nxt;
      edge_start_r    <= edge_start_nxt;
      pulse_width_r   <= pulse_width_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_item_r <= in_data;
    end
    if (stg_adv && stg_result) begin
      out_data_r.update_flags   <= pending_flags_r;
      out_data_r.throttle_width <= pulse_width_r[CH_THROTTLE];
      out_data_r.hover_width    <= pulse_width_r[CH_HOVER];
      out_data_r.pitch_width    <= pulse_width_r[CH_PITCH];
      out_data_r.roll_width     <= pulse_width_r[CH_ROLL];
      out_data_r.yaw_width      <= pulse_width_r[CH_YAW];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_out_has_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.update_flags != FLAG_NONE)
    else $error("result transfer carries no update flag");

  a_collect_clears: assert property (@(posedge clk) disable iff (!rst_n)
    stg_adv && stg_result |=> pending_flags_r == FLAG_NONE)
    else $error("flags not cleared after a collect");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stg_valid_r && !stg_adv |=> stg_valid_r && $stable(stg_item_r))
    else $error("stalled item lost from the input register");

  a_flags_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !stg_adv |=> $stable(pending_flags_r))
    else $error("flags changed without a processed item");

endmodule
